@@ rtl/dq_pkg.sv @@
// Shared constants, codes and types of the double-ended queue.
package dq_pkg;

    // Slot indexes wrap by truncation, so the capacity must be a power of two.
    localparam int CAPACITY    = 16;
    localparam int ELEM_BITS   = 32;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);

    localparam int CMD_W       = 3;
    localparam int POS_W       = 8;
    localparam int VALUE_W     = 32;
    localparam int STATUS_W    = 2;
    localparam int SIZE_W      = 5;
    localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CMD_W-1:0] CMD_PUSH_BACK   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_READ_INDEX  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_WRITE_INDEX = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ_FRONT  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ_BACK   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_WRITE_FRONT = 3'd6;
    localparam logic [CMD_W-1:0] CMD_WRITE_BACK  = 3'd7;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [1:0] {
        OP_PUSH_BACK,
        OP_PUSH_FRONT,
        OP_ACCESS
    } op_kind_t;

    typedef enum logic [1:0] {
        SEL_INDEX,
        SEL_FRONT,
        SEL_BACK
    } sel_t;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [POS_W-1:0]   position;
        logic [VALUE_W-1:0] value_in;
    } cmd_item_t;

    typedef struct packed {
        logic [VALUE_W-1:0]  value_out;
        logic [STATUS_W-1:0] status;
        logic [SIZE_W-1:0]   size;
        logic                is_empty;
    } result_t;

    typedef struct packed {
        op_kind_t             kind;
        sel_t                 sel;
        logic                 is_write;
        logic [POS_W-1:0]     position;
        logic [ELEM_BITS-1:0] value;
    } op_t;

endpackage

@@ rtl/dq_cmd_if.sv @@
// Command channel: valid/ready handshake carrying one command item.
interface dq_cmd_if
    import dq_pkg::*;
;
    logic      valid;
    logic      ready;
    cmd_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/dq_res_if.sv @@
// Result channel: valid/ready handshake carrying one result item.
interface dq_res_if
    import dq_pkg::*;
;
    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/dq_front.sv @@
// Command front end: accepts commands and classifies them into operations.
module dq_front
    import dq_pkg::*;
(
    dq_cmd_if.sink request,
    output logic   op_valid,
    output op_t    op,
    input  logic   op_ready
);

    always_comb
    begin
        op.position = request.data.position;
        op.value    = ELEM_BITS'(request.data.value_in);
        op.kind     = OP_ACCESS;
        op.sel      = SEL_INDEX;
        op.is_write = 1'b0;
        unique case (request.data.cmd)
            CMD_PUSH_BACK:
            begin
                op.kind = OP_PUSH_BACK;
            end
            CMD_PUSH_FRONT:
            begin
                op.kind = OP_PUSH_FRONT;
            end
            CMD_READ_INDEX:
            begin
                op.sel = SEL_INDEX;
            end
            CMD_WRITE_INDEX:
            begin
                op.sel      = SEL_INDEX;
                op.is_write = 1'b1;
            end
            CMD_READ_FRONT:
            begin
                op.sel = SEL_FRONT;
            end
            CMD_READ_BACK:
            begin
                op.sel = SEL_BACK;
            end
            CMD_WRITE_FRONT:
            begin
                op.sel      = SEL_FRONT;
                op.is_write = 1'b1;
            end
            CMD_WRITE_BACK:
            begin
                op.sel      = SEL_BACK;
                op.is_write = 1'b1;
            end
        endcase
    end

    assign op_valid      = request.valid;
    assign request.ready = op_ready;

endmodule

@@ rtl/dq_queue.sv @@
// Short operation queue between the front end and the execution unit.
module dq_queue
    import dq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  op_t  in_op,
    output logic in_ready,
    output logic out_valid,
    output op_t  out_op,
    input  logic out_ready
);

    op_t               entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] fill_reg;
    logic              push;
    logic              pop;

    assign in_ready  = (fill_reg != QCNT_W'(QUEUE_DEPTH));
    assign out_valid = (fill_reg != '0);
    assign out_op    = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_op;
        end
    end

endmodule

@@ rtl/dq_back.sv @@
// Execution unit: slot store, head pointer, element count and result register.
module dq_back
    import dq_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   op_valid,
    input  op_t    op,
    output logic   op_ready,
    dq_res_if.source response
);

    logic [ELEM_BITS-1:0] store_mem [CAPACITY];

    logic [ADDR_W-1:0]    head_reg;
    logic [ADDR_W-1:0]    head_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;

    logic                 out_valid_reg;
    logic                 rd_en_reg;
    logic [ELEM_BITS-1:0] rd_data_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic [STATUS_W-1:0]  status_next;
    logic [SIZE_W-1:0]    size_reg;
    logic                 empty_reg;

    logic                 take;
    logic                 full;
    logic                 empty;
    logic                 has_target;
    logic [ADDR_W-1:0]    target;
    logic [ADDR_W-1:0]    mem_addr;
    logic                 mem_we;
    logic                 mem_re;

    assign take     = op_valid && (!out_valid_reg || response.ready);
    assign op_ready = !out_valid_reg || response.ready;
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign empty    = (count_reg == '0);

    always_comb
    begin
        unique case (op.sel)
            SEL_INDEX:
            begin
                has_target = (CMP_W'(op.position) < CMP_W'(count_reg));
                target     = head_reg + ADDR_W'(op.position);
            end
            SEL_FRONT:
            begin
                has_target = !empty;
                target     = head_reg;
            end
            SEL_BACK:
            begin
                has_target = !empty;
                target     = head_reg + ADDR_W'(count_reg - 1'b1);
            end
            default:
            begin
                has_target = 1'b0;
                target     = head_reg;
            end
        endcase
    end

    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        status_next = ST_OK;
        mem_addr    = target;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        unique case (op.kind)
            OP_PUSH_BACK:
            begin
                mem_addr = head_reg + ADDR_W'(count_reg);
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    mem_we     = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            OP_PUSH_FRONT:
            begin
                mem_addr = head_reg - 1'b1;
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    mem_we     = 1'b1;
                    head_next  = head_reg - 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            OP_ACCESS:
            begin
                if (!has_target)
                begin
                    status_next = ST_RANGE;
                end
                else if (op.is_write)
                begin
                    mem_we = 1'b1;
                end
                else
                begin
                    mem_re = 1'b1;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                head_reg      <= head_next;
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (response.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The read port is registered; a stalled result keeps its read data.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            if (mem_we)
            begin
                store_mem[mem_addr] <= op.value;
            end
            rd_data_reg <= store_mem[mem_addr];
            rd_en_reg   <= mem_re;
            status_reg  <= status_next;
            size_reg    <= SIZE_W'(count_next);
            empty_reg   <= (count_next == '0);
        end
    end

    assign response.valid          = out_valid_reg;
    assign response.data.value_out = rd_en_reg ? VALUE_W'(rd_data_reg) : '0;
    assign response.data.status    = status_reg;
    assign response.data.size      = size_reg;
    assign response.data.is_empty  = empty_reg;

endmodule

@@ rtl/double_ended_queue_core.sv @@
// Double-ended queue with indexed access: front end, operation queue and execution unit.
//
//  Channel   Modport  Transfer carries
//  request   sink     cmd, position, value_in
//  response  source   value_out, status, size, is_empty
//
// One command per cycle is sustained while the response is not stalled; each
// command is registered first in the operation queue and then in the
// execution unit, whose single store port serves one read or write.
// Reset clears the head pointer, the element count and all handshake state;
// the slot store is not cleared and no clearing pass is needed.
// A stalled response holds the execution unit; the two-entry queue keeps
// accepting commands until it is full.
module double_ended_queue_core
    import dq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    dq_cmd_if.sink    request,
    dq_res_if.source  response
);

    logic op_valid;
    op_t  op;
    logic op_ready;
    logic q_valid;
    op_t  q_op;
    logic q_ready;

    dq_front u_front (
        .request  (request),
        .op_valid (op_valid),
        .op       (op),
        .op_ready (op_ready)
    );

    dq_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (op_valid),
        .in_op     (op),
        .in_ready  (op_ready),
        .out_valid (q_valid),
        .out_op    (q_op),
        .out_ready (q_ready)
    );

    dq_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (q_valid),
        .op       (q_op),
        .op_ready (q_ready),
        .response (response)
    );

    // The reported size can never exceed the capacity of the store.
    assert property (@(posedge clk) disable iff (!rst_n)
        response.valid |-> (response.data.size <= SIZE_W'(CAPACITY)))
        else $error("reported size exceeds capacity");

    // The empty flag must agree with the reported size.
    assert property (@(posedge clk) disable iff (!rst_n)
        response.valid |-> (response.data.is_empty == (response.data.size == '0)))
        else $error("empty flag disagrees with size");

    // A refused push is only reported when the store is full.
    assert property (@(posedge clk) disable iff (!rst_n)
        (response.valid && response.data.status == ST_FULL)
            |-> (response.data.size == SIZE_W'(CAPACITY)))
        else $error("full status with spare capacity");

    // Failed commands return no data.
    assert property (@(posedge clk) disable iff (!rst_n)
        (response.valid && response.data.status != ST_OK)
            |-> (response.data.value_out == '0))
        else $error("data returned on a failed command");

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the double-ended queue core with indexed access.
`timescale 1ns / 100ps

module testbench
    import dq_pkg::*;
;

    typedef struct {
        cmd_item_t   item;
        int unsigned reps;
        bit          fixed;
        result_t     answer;
    } script_row_t;

    logic clk = 1'b0;
    logic rst_n;

    dq_cmd_if request_ch ();
    dq_res_if response_ch ();

    double_ended_queue_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request_ch),
        .response (response_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Mirror of the queue contents, updated as each command transfer is taken.
    logic [ELEM_BITS-1:0] mirror_slots [CAPACITY];
    logic [ADDR_W-1:0]    mirror_head;
    logic [CNT_W-1:0]     mirror_count;

    result_t      awaited_replies [$];
    script_row_t  script [$];
    int unsigned  fault_count;
    int unsigned  sender_mode;
    int unsigned  receiver_mode;

    function automatic result_t predict_deque(input cmd_item_t item);
        result_t           reply;
        logic [ADDR_W-1:0] slot;
        logic              hit;
        reply.value_out = '0;
        reply.status    = ST_OK;
        slot            = '0;
        hit             = 1'b0;
        case (item.cmd)
            CMD_PUSH_BACK:
            begin
                if (mirror_count >= CAPACITY)
                    reply.status = ST_FULL;
                else
                begin
                    slot = mirror_head + mirror_count[ADDR_W-1:0];
                    mirror_slots[slot] = item.value_in[ELEM_BITS-1:0];
                    mirror_count = mirror_count + 1'b1;
                end
            end
            CMD_PUSH_FRONT:
            begin
                if (mirror_count >= CAPACITY)
                    reply.status = ST_FULL;
                else
                begin
                    mirror_head = mirror_head - 1'b1;
                    mirror_slots[mirror_head] = item.value_in[ELEM_BITS-1:0];
                    mirror_count = mirror_count + 1'b1;
                end
            end
            CMD_READ_INDEX, CMD_WRITE_INDEX:
            begin
                hit  = (item.position < mirror_count);
                slot = mirror_head + item.position[ADDR_W-1:0];
            end
            CMD_READ_FRONT, CMD_WRITE_FRONT:
            begin
                hit  = (mirror_count != 0);
                slot = mirror_head;
            end
            default:
            begin
                hit  = (mirror_count != 0);
                slot = mirror_head + mirror_count[ADDR_W-1:0] - 1'b1;
            end
        endcase
        if (item.cmd != CMD_PUSH_BACK && item.cmd != CMD_PUSH_FRONT)
        begin
            if (!hit)
                reply.status = ST_RANGE;
            else if (item.cmd == CMD_READ_INDEX || item.cmd == CMD_READ_FRONT ||
                     item.cmd == CMD_READ_BACK)
                reply.value_out = mirror_slots[slot];
            else
                mirror_slots[slot] = item.value_in[ELEM_BITS-1:0];
        end
        reply.size     = mirror_count;
        reply.is_empty = (mirror_count == 0);
        return reply;
    endfunction

    function automatic int unsigned pick_delay(input int unsigned mode);
        case (mode)
            0:       return 0;
            1:       return $urandom_range(0, 3);
            default: return $urandom_range(0, 12);
        endcase
    endfunction

    // Rows with a typed answer return nothing read, so only status and size vary.
    task automatic add_row(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] position,
                           input logic [VALUE_W-1:0] value, input int unsigned reps,
                           input bit fixed, input logic [STATUS_W-1:0] status,
                           input logic [SIZE_W-1:0] size);
        script_row_t row;
        row.item.cmd         = cmd;
        row.item.position    = position;
        row.item.value_in    = value;
        row.reps             = reps;
        row.fixed            = fixed;
        row.answer.value_out = '0;
        row.answer.status    = status;
        row.answer.size      = size;
        row.answer.is_empty  = (size == 0);
        script.insert(script.size(), row);
    endtask

    task automatic send_command(input cmd_item_t item, input bit fixed, input result_t answer);
        int unsigned gap;
        result_t     prediction;
        if ($urandom_range(0, 39) == 0)
            sender_mode = $urandom_range(0, 2);
        gap = pick_delay(sender_mode);
        if (gap > 0)
        begin
            request_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        request_ch.valid <= 1'b1;
        request_ch.data  <= item;
        do @(posedge clk); while (!request_ch.ready);
        prediction = predict_deque(item);
        awaited_replies.insert(awaited_replies.size(), fixed ? answer : prediction);
    endtask

    initial
    begin
        #4_000_000;
        $display("status: fail");
        $finish;
    end

    // Result side: random stalls, two long hold-offs, and the comparison.
    initial
    begin
        int unsigned stall;
        int unsigned seen;
        result_t     got;
        result_t     want;
        response_ch.ready <= 1'b0;
        seen = 0;
        receiver_mode = 2;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                receiver_mode = $urandom_range(0, 2);
            stall = (seen == 150 || seen == 1100) ? 80 : pick_delay(receiver_mode);
            if (stall > 0)
            begin
                response_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            response_ch.ready <= 1'b1;
            do @(posedge clk); while (!response_ch.valid);
            got  = response_ch.data;
            seen = seen + 1;
            if (awaited_replies.size() == 0)
            begin
                if (fault_count < 10)
                    $display("unexpected result: value %h status %0d size %0d empty %0d",
                             got.value_out, got.status, got.size, got.is_empty);
                fault_count = fault_count + 1;
            end
            else
            begin
                want = awaited_replies.pop_front();
                if (got.value_out !== want.value_out || got.status !== want.status ||
                    got.size !== want.size || got.is_empty !== want.is_empty)
                begin
                    if (fault_count < 10)
                        $display("mismatch: expected %h %0d %0d %0d, got %h %0d %0d %0d",
                                 want.value_out, want.status, want.size, want.is_empty,
                                 got.value_out, got.status, got.size, got.is_empty);
                    fault_count = fault_count + 1;
                end
            end
        end
    end

    initial
    begin
        script_row_t row;
        cmd_item_t   item;
        int unsigned pick;
        rst_n            <= 1'b0;
        request_ch.valid <= 1'b0;
        request_ch.data  <= '0;
        fault_count  = 0;
        sender_mode  = 2;
        mirror_head  = '0;
        mirror_count = '0;
        for (int i = 0; i < CAPACITY; i++)
            mirror_slots[i] = '0;

        // Every access on an empty queue is refused.
        add_row(CMD_READ_FRONT,  8'h00, 32'h0000_0000, 1, 1, ST_RANGE, 0);
        add_row(CMD_READ_BACK,   8'h00, 32'h0000_0000, 1, 1, ST_RANGE, 0);
        add_row(CMD_WRITE_FRONT, 8'h00, 32'hFFFF_FFFF, 1, 1, ST_RANGE, 0);
        add_row(CMD_WRITE_BACK,  8'hFF, 32'hDEAD_BEEF, 1, 1, ST_RANGE, 0);
        add_row(CMD_READ_INDEX,  8'h00, 32'h0000_0000, 1, 1, ST_RANGE, 0);
        add_row(CMD_WRITE_INDEX, 8'hFF, 32'hFFFF_FFFF, 1, 1, ST_RANGE, 0);
        add_row(CMD_PUSH_BACK,   8'hFF, 32'hFFFF_FFFF, 1, 1, ST_OK, 1);
        add_row(CMD_PUSH_FRONT,  8'h00, 32'h0000_0000, 1, 1, ST_OK, 2);
        add_row(CMD_READ_FRONT,  8'h00, 32'h0000_0000, 1, 0, ST_OK, 0);
        add_row(CMD_READ_BACK,   8'h00, 32'h0000_0000, 1, 0, ST_OK, 0);
        add_row(CMD_READ_INDEX,  8'h01, 32'h0000_0000, 1, 0, ST_OK, 0);
        add_row(CMD_READ_INDEX,  8'h02, 32'h0000_0000, 1, 1, ST_RANGE, 2);
        add_row(CMD_WRITE_INDEX, 8'h01, 32'hA5A5_A5A5, 1, 1, ST_OK, 2);
        add_row(CMD_WRITE_FRONT, 8'h00, 32'h5A5A_5A5A, 1, 1, ST_OK, 2);
        add_row(CMD_WRITE_BACK,  8'h00, 32'h1234_5678, 1, 0, ST_OK, 0);
        add_row(CMD_READ_INDEX,  8'h00, 32'h0000_0000, 1, 0, ST_OK, 0);
        add_row(CMD_READ_INDEX,  8'h01, 32'h0000_0000, 1, 0, ST_OK, 0);
        add_row(CMD_PUSH_FRONT,  8'h00, 32'h8000_0001, 7, 0, ST_OK, 0);
        add_row(CMD_READ_INDEX,  8'h05, 32'h0000_0000, 1, 0, ST_OK, 0);
        add_row(CMD_WRITE_INDEX, 8'h08, 32'hC3C3_3C3C, 1, 0, ST_OK, 0);
        add_row(CMD_PUSH_BACK,   8'h00, 32'h7FFF_FFF0, 7, 0, ST_OK, 0);
        add_row(CMD_PUSH_BACK,   8'h00, 32'h0BAD_F00D, 1, 1, ST_FULL, SIZE_W'(CAPACITY));
        add_row(CMD_PUSH_FRONT,  8'h00, 32'h0BAD_F00D, 1, 1, ST_FULL, SIZE_W'(CAPACITY));
        add_row(CMD_READ_INDEX,  8'h0F, 32'h0000_0000, 1, 0, ST_OK, 0);
        add_row(CMD_READ_INDEX,  8'h10, 32'h0000_0000, 1, 1, ST_RANGE, SIZE_W'(CAPACITY));
        add_row(CMD_READ_BACK,   8'h00, 32'h0000_0000, 1, 0, ST_OK, 0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[r])
        begin
            row = script[r];
            for (int unsigned k = 0; k < row.reps; k++)
            begin
                item          = row.item;
                item.value_in = row.item.value_in + k;
                send_command(item, row.fixed, row.answer);
            end
        end

        // There is no pop, so the queue stays full from here on; the random
        // part works the indexed and end accesses over every slot.
        for (int n = 0; n < 1900; n++)
        begin
            if (n == 950)
            begin
                request_ch.valid <= 1'b0;
                do @(posedge clk); while (awaited_replies.size() != 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 6)
                item.cmd = CMD_PUSH_BACK;
            else if (pick < 12)
                item.cmd = CMD_PUSH_FRONT;
            else if (pick < 36)
                item.cmd = CMD_READ_INDEX;
            else if (pick < 60)
                item.cmd = CMD_WRITE_INDEX;
            else if (pick < 70)
                item.cmd = CMD_READ_FRONT;
            else if (pick < 80)
                item.cmd = CMD_READ_BACK;
            else if (pick < 90)
                item.cmd = CMD_WRITE_FRONT;
            else
                item.cmd = CMD_WRITE_BACK;
            pick = $urandom_range(0, 9);
            if (pick < 8)
                item.position = POS_W'($urandom_range(0, CAPACITY - 1));
            else if (pick == 8)
                item.position = POS_W'($urandom_range(CAPACITY, 2 * CAPACITY - 1));
            else
                item.position = POS_W'($urandom_range(0, 255));
            pick = $urandom_range(0, 15);
            if (pick == 0)
                item.value_in = '0;
            else if (pick == 1)
                item.value_in = '1;
            else
                item.value_in = $urandom();
            send_command(item, 1'b0, '0);
        end

        request_ch.valid <= 1'b0;
        while (awaited_replies.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (fault_count == 0 && awaited_replies.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
